FILE: rtl/cdq_pkg.sv
package cdq_pkg;

    localparam int DEPTH      = 8;
    localparam int DATA_WIDTH = 32;
    localparam int PORT_WIDTH = 32;
    localparam int CFG_ADDR_W = 3;

    typedef logic [DATA_WIDTH-1:0] t_data;

    typedef enum logic [1:0] {
        OP_PUSH_RIGHT = 2'd0,
        OP_PUSH_LEFT  = 2'd1,
        OP_POP_LEFT   = 2'd2,
        OP_POP_RIGHT  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_OVERFLOW    = 2'd1,
        ST_UNDERFLOW   = 2'd2,
        ST_NOT_ALLOWED = 2'd3
    } t_status;

    localparam logic [1:0] MODE_INPUT_RESTRICTED  = 2'd1;
    localparam logic [1:0] MODE_OUTPUT_RESTRICTED = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] ADDR_RESTRICTION_MODE = CFG_ADDR_W'(0);

    typedef enum logic [2:0] {
        CELL_HOLD       = 3'd0,
        CELL_SHIFT_IN   = 3'd1,
        CELL_APPEND     = 3'd2,
        CELL_SHIFT_OUT  = 3'd3,
        CELL_DROP_RIGHT = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_data    push_data;
    } t_cell_ctl;

    function automatic t_data to_data(input logic [PORT_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [PORT_WIDTH-1:0] to_port(input t_data d);
        logic [63:0] w;
        w = 64'(d);
        return w[PORT_WIDTH-1:0];
    endfunction

endpackage

FILE: rtl/cdq_cell.sv
module cdq_cell
    import cdq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_data     i_left_data,
    input  logic      i_left_valid,
    input  t_data     i_right_data,
    input  logic      i_right_valid,
    output t_data     o_data,
    output logic      o_valid,
    output logic      o_last
);

    t_data r_data;
    t_data n_data;
    logic  r_valid;
    logic  n_valid;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        unique case (i_ctl.op)
            CELL_HOLD: begin
            end
            CELL_SHIFT_IN: begin
                n_data  = i_left_data;
                n_valid = i_left_valid;
            end
            CELL_APPEND: begin
                if (!r_valid && i_left_valid) begin
                    n_data  = i_ctl.push_data;
                    n_valid = 1'b1;
                end
            end
            CELL_SHIFT_OUT: begin
                n_data  = i_right_data;
                n_valid = i_right_valid;
            end
            CELL_DROP_RIGHT: begin
                if (r_valid && !i_right_valid) begin
                    n_valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;
    assign o_last  = r_valid && !i_right_valid;

endmodule

FILE: rtl/circular_deque_top.sv
// Double-ended queue of DEPTH entries held in a row of cells, the left end
// in the first cell, with each occupied cell marked by its own valid bit.
// Every accepted request (push right, push left, pop left, pop right) is
// finished in the cycle it is accepted: a push or pop at the left end shifts
// the whole row by one cell, and a push or pop at the right end acts only on
// the cell at the boundary of the occupied run. The result for a request
// appears in the output register on the cycle after it is accepted, and a new
// request is accepted in every cycle in which that register is empty or is
// being drained, so the block sustains one request per cycle under no stall.
// Refused requests (overflow, underflow, or forbidden by the restriction mode)
// leave the contents unchanged. The restriction mode register sits at byte
// address zero and should be written only while the block is idle.
module circular_deque_top
    import cdq_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [CFG_ADDR_W-1:0]        paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_in_opcode,
    input  logic signed [PORT_WIDTH-1:0] i_in_push_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [PORT_WIDTH-1:0] o_out_pop_value,
    output logic [1:0]                   o_out_status,
    output logic                         o_out_now_empty,
    output logic                         o_out_now_full
);

    logic [1:0] r_mode;

    logic                  r_out_valid;
    logic [PORT_WIDTH-1:0] r_pop_value;
    t_status               r_status;
    logic                  r_now_empty;
    logic                  r_now_full;

    logic [DEPTH-1:0][DATA_WIDTH-1:0] w_data;
    logic [DEPTH-1:0]                 w_valid;
    logic [DEPTH-1:0]                 w_last;

    t_opcode   w_op;
    logic      w_accept;
    t_status   w_status;
    t_cell_ctl w_ctl;
    t_data     w_right_value;
    t_data     w_pop_data;
    logic      w_empty;
    logic      w_full;
    logic      w_next_empty;
    logic      w_next_full;
    logic      w_is_push;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_RESTRICTION_MODE) ? {30'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 2'd0;
        end else if (psel && penable && pwrite && pready
                     && paddr == ADDR_RESTRICTION_MODE) begin
            r_mode <= pwdata[1:0];
        end
    end

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_op       = t_opcode'(i_in_opcode);
    assign w_empty    = !w_valid[0];
    assign w_full     = w_valid[DEPTH-1];
    assign w_is_push  = (w_op == OP_PUSH_RIGHT) || (w_op == OP_PUSH_LEFT);

    always_comb begin
        w_right_value = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (w_last[k]) begin
                w_right_value = w_right_value | t_data'(w_data[k]);
            end
        end
    end

    always_comb begin
        w_status   = ST_OK;
        w_pop_data = '0;
        if ((w_op == OP_PUSH_LEFT && r_mode == MODE_INPUT_RESTRICTED) ||
            (w_op == OP_POP_RIGHT && r_mode == MODE_OUTPUT_RESTRICTED)) begin
            w_status = ST_NOT_ALLOWED;
        end else if (w_is_push) begin
            if (w_full) begin
                w_status = ST_OVERFLOW;
            end
        end else if (w_empty) begin
            w_status = ST_UNDERFLOW;
        end else if (w_op == OP_POP_LEFT) begin
            w_pop_data = t_data'(w_data[0]);
        end else begin
            w_pop_data = w_right_value;
        end
    end

    always_comb begin
        w_ctl.push_data = to_data(PORT_WIDTH'($unsigned(i_in_push_value)));
        w_ctl.op        = CELL_HOLD;
        if (w_accept && w_status == ST_OK) begin
            unique case (w_op)
                OP_PUSH_RIGHT: w_ctl.op = CELL_APPEND;
                OP_PUSH_LEFT:  w_ctl.op = CELL_SHIFT_IN;
                OP_POP_LEFT:   w_ctl.op = CELL_SHIFT_OUT;
                OP_POP_RIGHT:  w_ctl.op = CELL_DROP_RIGHT;
                default:       w_ctl.op = CELL_HOLD;
            endcase
        end
    end

    always_comb begin
        w_next_empty = w_empty;
        w_next_full  = w_full;
        if (w_status == ST_OK) begin
            if (w_is_push) begin
                w_next_empty = 1'b0;
                w_next_full  = w_valid[DEPTH-2];
            end else begin
                w_next_empty = w_last[0];
                w_next_full  = 1'b0;
            end
        end
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        cdq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_left_data   ((k == 0) ? w_ctl.push_data : t_data'(w_data[(k == 0) ? 0 : k-1])),
            .i_left_valid  ((k == 0) ? 1'b1 : w_valid[(k == 0) ? 0 : k-1]),
            .i_right_data  ((k == DEPTH-1) ? t_data'(0)
                            : t_data'(w_data[(k == DEPTH-1) ? k : k+1])),
            .i_right_valid ((k == DEPTH-1) ? 1'b0 : w_valid[(k == DEPTH-1) ? k : k+1]),
            .o_data        (w_data[k]),
            .o_valid       (w_valid[k]),
            .o_last        (w_last[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_accept) begin
            r_pop_value <= to_port(w_pop_data);
            r_status    <= w_status;
            r_now_empty <= w_next_empty;
            r_now_full  <= w_next_full;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_pop_value = $signed(r_pop_value);
    assign o_out_status    = r_status;
    assign o_out_now_empty = r_now_empty;
    assign o_out_now_full  = r_now_full;

`ifndef SYNTH
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + DEPTH'(1))) == '0)
        else $error("Occupied cells do not form one run from the left end.");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_now_empty == !w_valid[0]))
        else $error("Reported empty flag disagrees with the cell row.");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_now_full == w_valid[DEPTH-1]))
        else $error("Reported full flag disagrees with the cell row.");

    a_refused_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_status != ST_OK) |=> $stable(w_valid))
        else $error("A refused request changed the occupancy.");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_status == ST_OK && w_is_push) |=> w_valid[0])
        else $error("A successful push left the deque empty.");
`endif

endmodule
